FILE: src/ism_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: shared package
// Lattice geometry, derived widths, reciprocal constants for the row/column
// split, field widths, codes and the types shared between the modules.
// ----------------------------------------------------------------------------
package ism_pkg;

  // Lattice geometry.
  localparam int SIDE_LENGTH = 64;
  localparam int SITE_COUNT  = SIDE_LENGTH * SIDE_LENGTH;
  localparam int ADDR_W      = $clog2(SITE_COUNT);
  localparam int XY_W        = $clog2(SIDE_LENGTH);

  // The row is site * RECIP >> DIV_SHIFT, exact for every site below 2**ADDR_W.
  localparam int DIV_SHIFT = ADDR_W + XY_W;
  localparam int RECIP_W   = ADDR_W + 2;
  localparam int RECIP     = (2 ** DIV_SHIFT + SIDE_LENGTH - 1) / SIDE_LENGTH;
  localparam int PROD_W    = ADDR_W + RECIP_W;

  // Internal totals are kept exactly: energy spans +/- 2N, the spin sum +/- N.
  localparam int ENERGY_W     = ADDR_W + 3;
  localparam int MSUM_W       = ADDR_W + 2;
  localparam int ENERGY_RESET = -2 * SITE_COUNT;
  localparam int MSUM_RESET   = SITE_COUNT;

  // Port field widths.
  localparam int SITE_IDX_W = 12;
  localparam int FRAC_W     = 32;
  localparam int DE_W       = 5;
  localparam int OUT_E_W    = 15;
  localparam int OUT_M_W    = 14;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Item modes.
  localparam logic MODE_TRIAL = 1'b0;
  localparam logic MODE_SET   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THR_DE4 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THR_DE8 = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVY,
    ST_DIVX,
    ST_LEFT,
    ST_RIGHT,
    ST_UP,
    ST_DOWN,
    ST_SUM,
    ST_COMMIT
  } ism_state_t;

  typedef enum logic [2:0] {
    NB_SITE,
    NB_LEFT,
    NB_RIGHT,
    NB_UP,
    NB_DOWN
  } nbr_sel_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic              wdata;
  } ram_req_t;

endpackage
`default_nettype wire

FILE: src/ism_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: input channel
// Valid/ready channel carrying one trial or set item.
// ----------------------------------------------------------------------------
interface ism_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [ism_pkg::SITE_IDX_W-1:0]     site_index;
  logic [ism_pkg::FRAC_W-1:0]         random_fraction;
  logic                               new_spin;

  modport source(output valid, mode, site_index, random_fraction, new_spin, input ready);
  modport sink(input valid, mode, site_index, random_fraction, new_spin, output ready);
endinterface
`default_nettype wire

FILE: src/ism_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: result channel
// Valid/ready channel carrying one result per item.
// ----------------------------------------------------------------------------
interface ism_out_if;
  logic                                valid;
  logic                                ready;
  logic                                flipped;
  logic signed [ism_pkg::DE_W-1:0]     energy_change;
  logic signed [ism_pkg::OUT_E_W-1:0]  total_energy;
  logic signed [ism_pkg::OUT_M_W-1:0]  magnet_sum;

  modport source(output valid, flipped, energy_change, total_energy, magnet_sum, input ready);
  modport sink(input valid, flipped, energy_change, total_energy, magnet_sum, output ready);
endinterface
`default_nettype wire

FILE: src/ism_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: configuration channel
// Valid/ready register write channel with register index and data.
// ----------------------------------------------------------------------------
interface ism_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ism_pkg::CFG_IDX_W-1:0]     index;
  logic [ism_pkg::CFG_DATA_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/ism_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module ism_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: src/ism_addr_gen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: neighbor address generator
// Splits the site into a registered row, then a registered column, and forms
// the periodic neighbor addresses with one add and a wrap select.
// ----------------------------------------------------------------------------
module ism_addr_gen (
  input  wire logic                       clk,
  input  wire logic [ism_pkg::ADDR_W-1:0] site,
  input  wire logic                       load_y,
  input  wire logic                       load_x,
  input  wire ism_pkg::nbr_sel_t          sel,
  output logic      [ism_pkg::ADDR_W-1:0] addr
);

  localparam int AW  = ism_pkg::ADDR_W;
  localparam int XW  = ism_pkg::XY_W;
  localparam int PW  = ism_pkg::PROD_W;

  localparam logic [PW-1:0] RECIP_C   = PW'(ism_pkg::RECIP);
  localparam logic [AW-1:0] SIDE_A    = AW'(ism_pkg::SIDE_LENGTH);
  localparam logic [AW:0]   SIDE_W    = (AW + 1)'(ism_pkg::SIDE_LENGTH);
  localparam logic [AW:0]   SIDE_M1_W = (AW + 1)'(ism_pkg::SIDE_LENGTH - 1);
  localparam logic [AW:0]   WRAP_W    = (AW + 1)'(ism_pkg::SITE_COUNT - ism_pkg::SIDE_LENGTH);
  localparam logic [AW:0]   ONE_W     = (AW + 1)'(1);
  localparam logic [XW-1:0] LAST_XY   = XW'(ism_pkg::SIDE_LENGTH - 1);

  logic [XW-1:0] y_r, y_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [PW-1:0] prod;
  logic [AW-1:0] row_base;
  logic [AW-1:0] col_full;
  logic [AW:0]   site_w;
  logic [AW:0]   addr_w;

  always_comb begin
    prod     = PW'(site) * RECIP_C;
    row_base = AW'(AW'(y_r) * SIDE_A);
    col_full = site - row_base;
    y_nxt    = load_y ? prod[ism_pkg::DIV_SHIFT +: XW] : y_r;
    x_nxt    = load_x ? col_full[XW-1:0] : x_r;
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
    x_r <= x_nxt;
  end

  always_comb begin
    site_w = {1'b0, site};
    case (sel)
      ism_pkg::NB_LEFT:  addr_w = (x_r == '0) ? site_w + SIDE_M1_W : site_w - ONE_W;
      ism_pkg::NB_RIGHT: addr_w = (x_r == LAST_XY) ? site_w - SIDE_M1_W : site_w + ONE_W;
      ism_pkg::NB_UP:    addr_w = (y_r == '0) ? site_w + WRAP_W : site_w - SIDE_W;
      ism_pkg::NB_DOWN:  addr_w = (y_r == LAST_XY) ? site_w - WRAP_W : site_w + SIDE_W;
      default:           addr_w = site_w;
    endcase
    addr = addr_w[AW-1:0];
  end

endmodule
`default_nettype wire

FILE: src/ism_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: sequencer and datapath
// Clears the lattice after reset, then walks each on-lattice item through the
// site read, four neighbor reads, the acceptance decision and the write-back,
// keeping the running energy and spin sum and the result register.
// ----------------------------------------------------------------------------
module ism_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ism_in_if.sink                              in_bus,
  ism_out_if.source                           out_bus,
  input  wire logic [ism_pkg::FRAC_W-1:0]     thr_de4,
  input  wire logic [ism_pkg::FRAC_W-1:0]     thr_de8,
  output ism_pkg::ram_req_t                   ram_req,
  input  wire logic                           ram_rdata
);

  localparam int AW = ism_pkg::ADDR_W;
  localparam int EW = ism_pkg::ENERGY_W;
  localparam int MW = ism_pkg::MSUM_W;

  localparam logic [AW-1:0]        LAST_ADDR = AW'(ism_pkg::SITE_COUNT - 1);
  localparam logic signed [MW-1:0] TWO_M     = MW'(2);

  ism_pkg::ism_state_t state_r, state_nxt;

  logic [AW-1:0]                   clr_cnt_r, clr_cnt_nxt;
  logic signed [EW-1:0]            energy_r, energy_nxt;
  logic signed [MW-1:0]            msum_r, msum_nxt;
  logic                            out_valid_r, out_valid_nxt;

  logic                            mode_r, mode_nxt;
  logic [AW-1:0]                   site_r, site_nxt;
  logic                            in_range_r, in_range_nxt;
  logic [ism_pkg::FRAC_W-1:0]      rnd_r, rnd_nxt;
  logic                            want_r, want_nxt;
  logic                            spin_r, spin_nxt;
  logic [2:0]                      cnt_r, cnt_nxt;
  logic                            out_flipped_r, out_flipped_nxt;
  logic signed [ism_pkg::DE_W-1:0]    out_de_r, out_de_nxt;
  logic signed [ism_pkg::OUT_E_W-1:0] out_energy_r, out_energy_nxt;
  logic signed [ism_pkg::OUT_M_W-1:0] out_msum_r, out_msum_nxt;

  ism_pkg::nbr_sel_t               sel;
  logic                            load_y;
  logic                            load_x;
  logic [AW-1:0]                   gen_addr;

  logic signed [5:0]               de_up;
  logic signed [5:0]               de_w;
  logic                            de_le0;
  logic [ism_pkg::FRAC_W-1:0]      thr_sel;
  logic                            trial_ok;
  logic                            changed;
  logic signed [EW-1:0]            energy_upd;
  logic signed [MW-1:0]            msum_upd;

  ism_addr_gen u_addr_gen (
    .clk    (clk),
    .site   (site_r),
    .load_y (load_y),
    .load_x (load_x),
    .sel    (sel),
    .addr   (gen_addr)
  );

  // Flip cost from the count of up neighbors: dE = 2*s*(2*count - 4).
  always_comb begin
    de_up    = $signed({1'b0, cnt_r, 2'b00}) - 6'sd8;
    de_w     = spin_r ? de_up : -de_up;
    de_le0   = de_w[5] || (de_w == 6'sd0);
    thr_sel  = (de_w == 6'sd4) ? thr_de4 : thr_de8;
    trial_ok = de_le0 || (rnd_r < thr_sel);
    if (mode_r == ism_pkg::MODE_SET) begin
      changed = in_range_r && (spin_r != want_r);
    end else begin
      changed = in_range_r && trial_ok;
    end
    energy_upd = changed ? energy_r + EW'(de_w) : energy_r;
    if (!changed) begin
      msum_upd = msum_r;
    end else if (spin_r) begin
      msum_upd = msum_r - TWO_M;
    end else begin
      msum_upd = msum_r + TWO_M;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    energy_nxt      = energy_r;
    msum_nxt        = msum_r;
    out_valid_nxt   = out_valid_r && !out_bus.ready;
    mode_nxt        = mode_r;
    site_nxt        = site_r;
    in_range_nxt    = in_range_r;
    rnd_nxt         = rnd_r;
    want_nxt        = want_r;
    spin_nxt        = spin_r;
    cnt_nxt         = cnt_r;
    out_flipped_nxt = out_flipped_r;
    out_de_nxt      = out_de_r;
    out_energy_nxt  = out_energy_r;
    out_msum_nxt    = out_msum_r;
    sel             = ism_pkg::NB_SITE;
    load_y          = 1'b0;
    load_x          = 1'b0;
    in_bus.ready    = 1'b0;
    ram_req.we      = 1'b0;
    ram_req.addr    = gen_addr;
    ram_req.wdata   = 1'b1;

    case (state_r)
      ism_pkg::ST_CLEAR: begin
        // Every spin starts at +1.
        ram_req.we   = 1'b1;
        ram_req.addr = clr_cnt_r;
        clr_cnt_nxt  = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ism_pkg::ST_IDLE;
        end
      end
      ism_pkg::ST_IDLE: begin
        in_bus.ready = 1'b1;
        if (in_bus.valid) begin
          mode_nxt     = in_bus.mode;
          site_nxt     = AW'(in_bus.site_index);
          in_range_nxt = 32'(in_bus.site_index) < ism_pkg::SITE_COUNT;
          rnd_nxt      = in_bus.random_fraction;
          want_nxt     = in_bus.new_spin;
          state_nxt    = in_range_nxt ? ism_pkg::ST_DIVY : ism_pkg::ST_COMMIT;
        end
      end
      ism_pkg::ST_DIVY: begin
        load_y    = 1'b1;
        state_nxt = ism_pkg::ST_DIVX;
      end
      ism_pkg::ST_DIVX: begin
        spin_nxt  = ram_rdata;
        load_x    = 1'b1;
        state_nxt = ism_pkg::ST_LEFT;
      end
      ism_pkg::ST_LEFT: begin
        sel       = ism_pkg::NB_LEFT;
        state_nxt = ism_pkg::ST_RIGHT;
      end
      ism_pkg::ST_RIGHT: begin
        sel       = ism_pkg::NB_RIGHT;
        cnt_nxt   = {2'b00, ram_rdata};
        state_nxt = ism_pkg::ST_UP;
      end
      ism_pkg::ST_UP: begin
        sel       = ism_pkg::NB_UP;
        cnt_nxt   = cnt_r + {2'b00, ram_rdata};
        state_nxt = ism_pkg::ST_DOWN;
      end
      ism_pkg::ST_DOWN: begin
        sel       = ism_pkg::NB_DOWN;
        cnt_nxt   = cnt_r + {2'b00, ram_rdata};
        state_nxt = ism_pkg::ST_SUM;
      end
      ism_pkg::ST_SUM: begin
        cnt_nxt   = cnt_r + {2'b00, ram_rdata};
        state_nxt = ism_pkg::ST_COMMIT;
      end
      ism_pkg::ST_COMMIT: begin
        // Wait here while the previous result has not been transferred.
        if (!out_valid_r || out_bus.ready) begin
          ram_req.we      = changed;
          ram_req.wdata   = ~spin_r;
          energy_nxt      = energy_upd;
          msum_nxt        = msum_upd;
          out_valid_nxt   = 1'b1;
          out_flipped_nxt = changed;
          out_de_nxt      = changed ? de_w[ism_pkg::DE_W-1:0] : '0;
          out_energy_nxt  = ism_pkg::OUT_E_W'(energy_upd);
          out_msum_nxt    = ism_pkg::OUT_M_W'(msum_upd);
          state_nxt       = ism_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ism_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ism_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      energy_r    <= EW'(ism_pkg::ENERGY_RESET);
      msum_r      <= MW'(ism_pkg::MSUM_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      energy_r    <= energy_nxt;
      msum_r      <= msum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    site_r        <= site_nxt;
    in_range_r    <= in_range_nxt;
    rnd_r         <= rnd_nxt;
    want_r        <= want_nxt;
    spin_r        <= spin_nxt;
    cnt_r         <= cnt_nxt;
    out_flipped_r <= out_flipped_nxt;
    out_de_r      <= out_de_nxt;
    out_energy_r  <= out_energy_nxt;
    out_msum_r    <= out_msum_nxt;
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.flipped       = out_flipped_r;
  assign out_bus.energy_change = out_de_r;
  assign out_bus.total_energy  = out_energy_r;
  assign out_bus.magnet_sum    = out_msum_r;

endmodule
`default_nettype wire

FILE: src/ising_metropolis_spin_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: top level
// Periodic square Ising lattice with Metropolis trials and spin writes.
// ----------------------------------------------------------------------------
// After reset the block walks every site of the lattice, setting each spin to
// +1, with in_bus.ready low; configuration writes are taken throughout. An
// item for a site on the lattice then occupies the block from its transfer to
// the next transfer: the spins live in a single-port RAM, so the site read,
// the four neighbor reads and the write-back each need a RAM access of their
// own, and the row/column split of the site index takes a reciprocal-multiply
// step for the row and then a subtraction step for the column. An item for a
// site off the lattice skips the reads and goes straight to the commit step.
// The result is held in an output register; an item is taken while it waits,
// and the next result waits in the commit step until it is taken. total_energy
// and magnet_sum wrap to their field widths on lattices larger than 64 x 64.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ism_in_if.sink     in_bus,
  ism_out_if.source  out_bus,
  ism_cfg_if.sink    cfg_bus
);

  logic [ism_pkg::FRAC_W-1:0] thr_de4_r, thr_de4_nxt;
  logic [ism_pkg::FRAC_W-1:0] thr_de8_r, thr_de8_nxt;
  ism_pkg::ram_req_t          ram_req;
  logic                       ram_rdata;

  assign cfg_bus.ready = 1'b1;

  always_comb begin
    thr_de4_nxt = thr_de4_r;
    thr_de8_nxt = thr_de8_r;
    if (cfg_bus.valid) begin
      case (cfg_bus.index)
        ism_pkg::CFG_IDX_THR_DE4: thr_de4_nxt = cfg_bus.data;
        ism_pkg::CFG_IDX_THR_DE8: thr_de8_nxt = cfg_bus.data;
        default: begin
          thr_de4_nxt = thr_de4_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_de4_r <= '0;
      thr_de8_r <= '0;
    end else begin
      thr_de4_r <= thr_de4_nxt;
      thr_de8_r <= thr_de8_nxt;
    end
  end

  ism_ram #(
    .WIDTH (1),
    .DEPTH (ism_pkg::SITE_COUNT)
  ) u_lattice (
    .clk   (clk),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  ism_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .thr_de4   (thr_de4_r),
    .thr_de8   (thr_de8_r),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: testbench
// Drives trials and spin writes over the periodic lattice under several
// acceptance thresholds, with random idling on both channels, and checks
// every result against a behavioral model of the lattice and its totals.
// ----------------------------------------------------------------------------
module testbench;
  import ism_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 300;
  localparam int LONG_HOLD_AT   = 700;
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_ITEMS    = 322;
  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

  typedef struct packed {
    logic                  mode;
    logic [SITE_IDX_W-1:0] site;
    logic [FRAC_W-1:0]     rnd;
    logic                  new_spin;
  } spin_item_t;

  typedef struct packed {
    logic                      flipped;
    logic signed [DE_W-1:0]    de;
    logic signed [OUT_E_W-1:0] energy;
    logic signed [OUT_M_W-1:0] magnet;
  } spin_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    spin_item_t            item;
    bit                    has_known;
    spin_result_t          known;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
  } directed_row_t;

  logic clk;
  logic rst_n;

  ism_in_if  in_bus();
  ism_out_if out_bus();
  ism_cfg_if cfg_bus();

  ising_metropolis_spin_update dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Model state: lattice, exact totals and the two acceptance thresholds.
  bit                lattice [SITE_COUNT];
  int                lattice_energy;
  int                lattice_magnet;
  logic [FRAC_W-1:0] thr_de4;
  logic [FRAC_W-1:0] thr_de8;

  spin_result_t  expected_results [$];
  directed_row_t directed_rows [$];
  int            err_count;
  int            results_seen;
  bit            in_burst;
  bit            out_burst;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int spin_at(int site);
    return lattice[site] ? 1 : -1;
  endfunction

  function automatic int flip_cost(int site);
    int x, y, xl, xr, yu, yd, nsum;
    x    = site % SIDE_LENGTH;
    y    = site / SIDE_LENGTH;
    xl   = (x + SIDE_LENGTH - 1) % SIDE_LENGTH;
    xr   = (x + 1) % SIDE_LENGTH;
    yu   = (y + SIDE_LENGTH - 1) % SIDE_LENGTH;
    yd   = (y + 1) % SIDE_LENGTH;
    nsum = spin_at(y * SIDE_LENGTH + xl) + spin_at(y * SIDE_LENGTH + xr)
         + spin_at(yu * SIDE_LENGTH + x) + spin_at(yd * SIDE_LENGTH + x);
    return 2 * spin_at(site) * nsum;
  endfunction

  function automatic spin_result_t metropolis_update(spin_item_t it);
    spin_result_t res;
    int           site;
    int           cost;
    bit           changed;
    site    = int'(it.site);
    cost    = 0;
    changed = 1'b0;
    if (site < SITE_COUNT) begin
      cost = flip_cost(site);
      if (it.mode == MODE_TRIAL) begin
        if (cost <= 0) changed = 1'b1;
        else if (cost == 4) changed = (it.rnd < thr_de4);
        else changed = (it.rnd < thr_de8);
      end else begin
        changed = (lattice[site] != it.new_spin);
      end
      if (changed) begin
        lattice_energy += cost;
        lattice_magnet -= 2 * spin_at(site);
        lattice[site]   = !lattice[site];
      end
    end
    res.flipped = changed;
    res.de      = changed ? DE_W'(cost) : '0;
    res.energy  = OUT_E_W'(lattice_energy);
    res.magnet  = OUT_M_W'(lattice_magnet);
    return res;
  endfunction

  function automatic void add_item(logic mode, int site, logic [FRAC_W-1:0] rnd,
                                   logic spin, bit has_known = 1'b0, logic flip = 1'b0,
                                   int de = 0, int energy = 0, int magnet = 0);
    directed_row_t row;
    row.kind           = ROW_ITEM;
    row.item.mode      = mode;
    row.item.site      = SITE_IDX_W'(site);
    row.item.rnd       = rnd;
    row.item.new_spin  = spin;
    row.has_known      = has_known;
    row.known.flipped  = flip;
    row.known.de       = DE_W'(de);
    row.known.energy   = OUT_E_W'(energy);
    row.known.magnet   = OUT_M_W'(magnet);
    row.cfg_index      = '0;
    row.cfg_data       = '0;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    directed_row_t row;
    row.kind      = ROW_CFG;
    row.item      = '0;
    row.has_known = 1'b0;
    row.known     = '0;
    row.cfg_index = index;
    row.cfg_data  = data;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Leaves valid high after the transfer so that back-to-back items keep it
  // asserted; wait_idle, or the next call when it idles first, lowers it.
  task automatic send_item(spin_item_t it, bit has_known, spin_result_t known);
    int           gap;
    spin_result_t predicted;
    gap = in_burst ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.mode            <= it.mode;
    in_bus.site_index      <= it.site;
    in_bus.random_fraction <= it.rnd;
    in_bus.new_spin        <= it.new_spin;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    predicted = metropolis_update(it);
    expected_results.insert(expected_results.size(), has_known ? known : predicted);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    if (index == CFG_IDX_THR_DE4) thr_de4 = data;
    else if (index == CFG_IDX_THR_DE8) thr_de8 = data;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid  <= 1'b0;
    cfg_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int           gap;
    spin_result_t got;
    spin_result_t want;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (results_seen % 64 == 0) out_burst = ($urandom_range(0, 2) == 0);
      if (results_seen == LONG_HOLD_AT) gap = LONG_HOLD;
      else gap = out_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      got.flipped = out_bus.flipped;
      got.de      = out_bus.energy_change;
      got.energy  = out_bus.total_energy;
      got.magnet  = out_bus.magnet_sum;
      results_seen++;
      if (expected_results.size() == 0) begin
        err_count++;
        $display("%0t: result with none expected, expected nothing, actual %0d %0d %0d %0d",
                 $time, got.flipped, got.de, got.energy, got.magnet);
      end else begin
        want = expected_results.pop_front();
        check_field("flipped", int'(want.flipped), int'(got.flipped));
        check_field("energy_change", int'(want.de), int'(got.de));
        check_field("total_energy", int'(want.energy), int'(got.energy));
        check_field("magnet_sum", int'(want.magnet), int'(got.magnet));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
          (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    spin_item_t            it;
    int                    x, y;
    logic [CFG_DATA_W-1:0] de4, de8;

    foreach (lattice[i]) lattice[i] = 1'b1;
    lattice_energy = ENERGY_RESET;
    lattice_magnet = MSUM_RESET;
    thr_de4        = '0;
    thr_de8        = '0;
    err_count      = 0;
    results_seen   = 0;
    in_burst       = 1'b0;
    out_burst      = 1'b0;

    rst_n                  = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.mode            = MODE_TRIAL;
    in_bus.site_index      = '0;
    in_bus.random_fraction = '0;
    in_bus.new_spin        = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = CFG_IDX_THR_DE4;
    cfg_bus.data           = '0;

    // Fully aligned lattice with zero thresholds: nothing uphill is accepted.
    add_item(MODE_TRIAL, 0, '0, 1'b0, 1'b1, 1'b0, 0, -8192, 4096);
    add_item(MODE_TRIAL, 4095, FRAC_MAX, 1'b0, 1'b1, 1'b0, 0, -8192, 4096);
    add_item(MODE_SET, 0, '0, 1'b1, 1'b1, 1'b0, 0, -8192, 4096);
    add_item(MODE_SET, 0, '0, 1'b0, 1'b1, 1'b1, 8, -8184, 4094);
    add_item(MODE_TRIAL, 0, FRAC_MAX, 1'b0, 1'b1, 1'b1, -8, -8192, 4096);
    add_item(MODE_SET, 100, '0, 1'b0, 1'b1, 1'b1, 8, -8184, 4094);
    add_item(MODE_TRIAL, 101, '0, 1'b0, 1'b1, 1'b0, 0, -8184, 4094);
    // The threshold comparison is strict: a draw equal to it is rejected.
    add_cfg(CFG_IDX_THR_DE4, 32'h8000_0000);
    add_item(MODE_TRIAL, 101, 32'h8000_0000, 1'b0, 1'b1, 1'b0, 0, -8184, 4094);
    add_item(MODE_TRIAL, 101, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 4, -8180, 4092);
    add_item(MODE_TRIAL, 101, FRAC_MAX, 1'b0, 1'b1, 1'b1, -4, -8184, 4094);
    // Two anti-aligned neighbors give a zero-cost flip.
    add_item(MODE_SET, 200, '0, 1'b0);
    add_item(MODE_SET, 202, '0, 1'b0);
    add_item(MODE_TRIAL, 201, FRAC_MAX, 1'b0);
    add_cfg(CFG_IDX_THR_DE8, FRAC_MAX);
    add_item(MODE_TRIAL, 4095, FRAC_MAX, 1'b0);
    add_item(MODE_TRIAL, 4095, FRAC_MAX - 1, 1'b0);
    // Sites on the lattice border see neighbors across the periodic wrap.
    add_item(MODE_TRIAL, 63, '0, 1'b0);
    add_item(MODE_SET, 4032, '0, 1'b1);
    add_item(MODE_TRIAL, 0, '0, 1'b0);
    add_cfg(CFG_IDX_THR_DE4, '0);
    add_cfg(CFG_IDX_THR_DE8, '0);
    add_item(MODE_SET, 0, '0, 1'b1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[i].cfg_index, directed_rows[i].cfg_data);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].has_known,
                  directed_rows[i].known);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin de4 = '0; de8 = '0; end
        1: begin de4 = FRAC_MAX; de8 = FRAC_MAX; end
        // Thresholds near the critical temperature.
        2: begin de4 = 32'h2BE7_6C8B; de8 = 32'h0788_2A70; end
        3: begin de4 = 32'h8000_0000; de8 = 32'h0000_0001; end
        4: begin de4 = $urandom; de8 = $urandom; end
        default: begin de4 = '0; de8 = FRAC_MAX; end
      endcase
      wait_idle();
      write_reg(CFG_IDX_THR_DE4, de4);
      write_reg(CFG_IDX_THR_DE8, de8);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 80 == 0) in_burst = ($urandom_range(0, 2) == 0);
        x = $urandom_range(0, SIDE_LENGTH - 1);
        y = $urandom_range(0, SIDE_LENGTH - 1);
        case ($urandom_range(0, 7))
          0: x = ($urandom_range(0, 1) == 1) ? SIDE_LENGTH - 1 : 0;
          1: y = ($urandom_range(0, 1) == 1) ? SIDE_LENGTH - 1 : 0;
          default: ;
        endcase
        it.site     = SITE_IDX_W'(y * SIDE_LENGTH + x);
        it.mode     = ($urandom_range(0, 4) == 0) ? MODE_SET : MODE_TRIAL;
        it.new_spin = 1'($urandom_range(0, 1));
        // Draws are pulled toward the thresholds to probe the strict compare.
        case ($urandom_range(0, 9))
          0: it.rnd = '0;
          1: it.rnd = FRAC_MAX;
          2: it.rnd = thr_de4 + FRAC_W'($urandom_range(0, 2)) - 1;
          3: it.rnd = thr_de8 + FRAC_W'($urandom_range(0, 2)) - 1;
          default: it.rnd = $urandom;
        endcase
        send_item(it, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
